[hdl/deq_pkg.sv]
// Package: shared constants, codes and request/result types for the deque.
`default_nettype none
package deq_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int OCC_W        = 9;

  // action codes
  localparam logic [1:0] ACT_PUSH_FRONT = 2'd0;
  localparam logic [1:0] ACT_PUSH_BACK  = 2'd1;
  localparam logic [1:0] ACT_POP_FRONT  = 2'd2;
  localparam logic [1:0] ACT_POP_BACK   = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic [1:0]         status;
    logic [OCC_W-1:0]   occupancy;
  } rsp_t;

endpackage
`default_nettype wire

[hdl/deq_ram.sv]
// Single-port synchronous word store with registered read data.
`default_nettype none
module deq_ram #(
  parameter int DEPTH = deq_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic          re,
  input  wire logic [AW-1:0] addr,
  input  wire logic [31:0]   wdata,
  output logic [31:0]        rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

[hdl/deq_ctrl.sv]
// Deque control: front index, element count, ring addressing and status.
`default_nettype none
module deq_ctrl #(
  parameter int CAPACITY = deq_pkg::CAPACITY_DEF,
  parameter int IDX_W    = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire deq_pkg::cmd_t         cmd,
  output logic                       busy,
  output logic                       mem_we,
  output logic                       mem_re,
  output logic [IDX_W-1:0]           mem_addr,
  output logic [31:0]                mem_wdata,
  output logic                       done,
  output logic                       pop_ok,
  output logic [1:0]                 status,
  output logic [deq_pkg::OCC_W-1:0]  occupancy
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W:0]   CAP_SUM  = (CNT_W + 1)'(CAPACITY);

  logic [IDX_W-1:0] front, front_next;
  logic [CNT_W-1:0] count, count_next;

  logic             accept, is_full, is_empty;
  logic [IDX_W-1:0] front_inc, front_dec, back_pos;
  logic [CNT_W-1:0] back_off;
  logic [CNT_W:0]   back_sum;
  logic [1:0]       status_next;
  logic             pop_ok_next;
  logic [CNT_W+deq_pkg::OCC_W-1:0] occ_ext;

  assign accept   = start & ~busy;
  assign is_full  = (count == CNT_W'(CAPACITY));
  assign is_empty = (count == '0);

  assign front_inc = (front == IDX_LAST) ? '0 : front + IDX_W'(1);
  assign front_dec = (front == '0) ? IDX_LAST : front - IDX_W'(1);

  // back end: front + count for a push, front + count - 1 for a pop
  assign back_off = cmd.action[1] ? count - CNT_W'(1) : count;
  assign back_sum = (CNT_W + 1)'(front) + (CNT_W + 1)'(back_off);
  assign back_pos = (back_sum >= CAP_SUM) ? IDX_W'(back_sum - CAP_SUM)
                                          : IDX_W'(back_sum);

  always_comb begin
    front_next  = front;
    count_next  = count;
    status_next = deq_pkg::ST_DONE;
    pop_ok_next = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = front;
    mem_wdata   = cmd.push_value;
    if (accept) begin
      unique case (cmd.action)
        deq_pkg::ACT_PUSH_FRONT: begin
          if (is_full) begin
            status_next = deq_pkg::ST_FULL;
          end else begin
            front_next = front_dec;
            count_next = count + CNT_W'(1);
            mem_we     = 1'b1;
            mem_addr   = front_dec;
          end
        end
        deq_pkg::ACT_PUSH_BACK: begin
          if (is_full) begin
            status_next = deq_pkg::ST_FULL;
          end else begin
            count_next = count + CNT_W'(1);
            mem_we     = 1'b1;
            mem_addr   = back_pos;
          end
        end
        deq_pkg::ACT_POP_FRONT: begin
          if (is_empty) begin
            status_next = deq_pkg::ST_EMPTY;
          end else begin
            front_next  = front_inc;
            count_next  = count - CNT_W'(1);
            mem_re      = 1'b1;
            pop_ok_next = 1'b1;
            mem_addr    = front;
          end
        end
        deq_pkg::ACT_POP_BACK: begin
          if (is_empty) begin
            status_next = deq_pkg::ST_EMPTY;
          end else begin
            count_next  = count - CNT_W'(1);
            mem_re      = 1'b1;
            pop_ok_next = 1'b1;
            mem_addr    = back_pos;
          end
        end
        default: begin
          status_next = deq_pkg::ST_DONE;
        end
      endcase
    end
  end

  assign occ_ext = {{deq_pkg::OCC_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b1;
      front  <= '0;
      count  <= '0;
      done   <= 1'b0;
      pop_ok <= 1'b0;
    end else begin
      busy   <= 1'b0;
      front  <= front_next;
      count  <= count_next;
      done   <= accept;
      pop_ok <= pop_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    status    <= status_next;
    occupancy <= occ_ext[deq_pkg::OCC_W-1:0];
  end

endmodule
`default_nettype wire

[hdl/double_ended_queue.sv]
// Top level of the bounded double-ended queue of signed 32-bit words.
// A request accepted at one clock edge has its result on rsp, with done high,
// in the cycle that follows; the entry read for a pop comes from the
// single-port word store, whose read port is registered.
// Throughput: one request per cycle; busy is high only in reset and the cycle
// after it. Reset clears front index and count; stored words are left as is.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module double_ended_queue #(
  parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire deq_pkg::cmd_t cmd,
  output logic               busy,
  output logic               done,
  output deq_pkg::rsp_t      rsp
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // store port, driven by the controller
  logic             mem_we;
  logic             mem_re;
  logic [IDX_W-1:0] mem_addr;
  logic [31:0]      mem_wdata;
  logic [31:0]      mem_rdata;

  // registered result fields
  logic                      pop_ok;
  logic [1:0]                status;
  logic [deq_pkg::OCC_W-1:0] occupancy;

  deq_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .done      (done),
    .pop_ok    (pop_ok),
    .status    (status),
    .occupancy (occupancy)
  );

  deq_ram #(
    .DEPTH (CAPACITY),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // popped word only on a successful pop; zero for pushes and rejections
  always_comb begin
    rsp.popped_value = pop_ok ? mem_rdata : '0;
    rsp.status       = status;
    rsp.occupancy    = occupancy;
  end

  // a result follows exactly one accepted request
  a_done_follows_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result without a request");

  // an empty rejection means the queue holds nothing
  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == deq_pkg::ST_EMPTY) |-> rsp.occupancy == '0)
    else $error("empty status with non-zero occupancy");

  // a non-zero popped word only comes from a successful pop request
  a_pop_word: assert property (@(posedge clk) disable iff (rst)
    (rsp.popped_value != '0) |->
      (done && rsp.status == deq_pkg::ST_DONE && $past(cmd.action[1])))
    else $error("popped word outside a successful pop");

endmodule
`default_nettype wire
